/* rtl/core/gdad_pkg.sv */
// Package for the Gregorian date adder: field widths, calendar constants,
// sequencer states and the month-length function.
// No dependencies.
package gdad_pkg;

	localparam int YEAR_W    = 14;
	localparam int MONTH_W   = 4;
	localparam int DAY_OUT_W = 5;
	localparam int REM_W     = 9;

	localparam logic [YEAR_W-1:0]    MAX_YEAR   = 14'd9999;
	localparam logic [YEAR_W-1:0]    MIN_YEAR   = 14'd1;
	localparam logic [REM_W-1:0]     LEAP_CYCLE = 9'd400;
	localparam logic [REM_W-1:0]     CENTURY    = 9'd100;
	localparam logic [MONTH_W-1:0]   JANUARY    = 4'd1;
	localparam logic [MONTH_W-1:0]   FEBRUARY   = 4'd2;
	localparam logic [MONTH_W-1:0]   DECEMBER   = 4'd12;
	localparam logic [DAY_OUT_W-1:0] FIRST_DAY  = 5'd1;
	localparam logic [DAY_OUT_W-1:0] LAST_DAY   = 5'd31;
	localparam logic [DAY_OUT_W-1:0] LEAP_FEB   = 5'd29;

	// The year is reduced modulo 400 by restoring steps of 400 * 2^k, k = 4..0.
	localparam int MOD_STEPS = 5;
	localparam int STEP_W    = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_RUN
	} gdad_state_t;

	// Length of a month; the month is already clamped to 1..12.
	function automatic logic [DAY_OUT_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_OUT_W-1:0] len;
		case (m)
			4'd2:                  len = leap ? LEAP_FEB : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:               len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* rtl/core/gregorian_date_add_days_top.sv */
// Gregorian date adder: adds a day count to a date with one shared subtractor.
// Depends on gdad_pkg.

// A date word (year, month, day, count) is taken on start while busy is low.
// The block first reduces the year modulo 400 in five compare-and-subtract
// steps, then walks forward one month per cycle, subtracting the month length
// from the running day with the same subtractor. A start year above 9999
// skips both phases and saturates directly, with busy staying low throughout.
// The result is presented for exactly one cycle with done high and must be
// captured then, since the receiver cannot stall the block. Out-of-range
// inputs are clamped (year 0 and day 0 to 1, month 0 to January, months above
// 12 to December), and a result past 9999-12-31 saturates with year_overflow.
module gregorian_date_add_days_top #(
	parameter int ADD_WIDTH = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [gdad_pkg::YEAR_W-1:0]     start_year,
	input  logic [gdad_pkg::MONTH_W-1:0]    start_month,
	input  logic [gdad_pkg::DAY_OUT_W-1:0]  start_day,
	input  logic [ADD_WIDTH-1:0]            days_to_add,
	output logic                            done,
	output logic [gdad_pkg::YEAR_W-1:0]     result_year,
	output logic [gdad_pkg::MONTH_W-1:0]    result_month,
	output logic [gdad_pkg::DAY_OUT_W-1:0]  result_day,
	output logic                            year_overflow
);
	import gdad_pkg::*;

	// The running day holds start day plus count before any month is removed.
	localparam int DAY_W = ADD_WIDTH + 1;
	localparam int SUB_W = (DAY_W > YEAR_W) ? DAY_W : YEAR_W;

	gdad_state_t state_q, state_d;

	logic [YEAR_W-1:0]    year_q;
	logic [MONTH_W-1:0]   month_q;
	logic [DAY_W-1:0]     day_q;
	logic [YEAR_W-1:0]    rem_q;
	logic [STEP_W-1:0]    step_q;
	logic                 done_q;
	logic [YEAR_W-1:0]    res_year_q;
	logic [MONTH_W-1:0]   res_month_q;
	logic [DAY_OUT_W-1:0] res_day_q;
	logic                 res_ovf_q;

	// Clamped input fields.
	logic [YEAR_W-1:0]    in_year;
	logic [MONTH_W-1:0]   in_month;
	logic [DAY_OUT_W-1:0] in_day;
	logic                 accept;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_year  = (start_year == '0) ? MIN_YEAR : start_year;
	assign in_month = (start_month == '0) ? JANUARY :
			(start_month > DECEMBER) ? DECEMBER : start_month;
	assign in_day   = (start_day == '0) ? FIRST_DAY : start_day;

	// Leap test from the year modulo 400.
	logic                 leap;
	logic [DAY_OUT_W-1:0] dim;
	logic [REM_W-1:0]     rem_lo;

	assign rem_lo = rem_q[REM_W-1:0];
	assign leap   = (rem_lo[1:0] == 2'b00) && (rem_lo != CENTURY) &&
			(rem_lo != REM_W'(2 * CENTURY)) && (rem_lo != REM_W'(3 * CENTURY));
	assign dim    = month_days(month_q, leap);

	// Shared subtractor: year reduction steps, then month-length removal.
	logic [SUB_W-1:0] op_a, op_b;
	logic [SUB_W:0]   diff;
	logic             borrow;
	logic             zero;

	always_comb begin
		if (state_q == ST_MOD) begin
			op_a = SUB_W'(rem_q);
			op_b = SUB_W'({{(YEAR_W-REM_W){1'b0}}, LEAP_CYCLE} << step_q);
		end else begin
			op_a = SUB_W'(day_q);
			op_b = SUB_W'(dim);
		end
	end

	assign diff   = {1'b0, op_a} - {1'b0, op_b};
	assign borrow = diff[SUB_W];
	assign zero   = (diff[SUB_W-1:0] == '0);

	// Day fits in the current month when day <= length.
	logic fits;
	logic last_year;

	assign fits      = borrow || zero;
	assign last_year = (month_q == DECEMBER) && (year_q == MAX_YEAR);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (start_year <= MAX_YEAR)) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (step_q == '0) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (fits || last_year) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Work registers and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			rem_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						year_q  <= in_year;
						month_q <= in_month;
						day_q   <= DAY_W'(in_day) + DAY_W'(days_to_add);
						rem_q   <= in_year;
						step_q  <= STEP_W'(MOD_STEPS - 1);
					end
				end
				ST_MOD: begin
					if (!borrow) begin
						rem_q <= diff[YEAR_W-1:0];
					end
					step_q <= step_q - 1'b1;
				end
				ST_RUN: begin
					if (!fits && !last_year) begin
						day_q <= diff[DAY_W-1:0];
						if (month_q == DECEMBER) begin
							month_q <= JANUARY;
							year_q  <= year_q + 1'b1;
							rem_q   <= (rem_lo == LEAP_CYCLE - 1'b1) ? '0 : rem_q + 1'b1;
						end else begin
							month_q <= month_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result word and its one-cycle strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (start_year > MAX_YEAR)) ||
					((state_q == ST_RUN) && (fits || last_year));
		end
	end

	always_ff @(posedge clk) begin
		if ((accept && (start_year > MAX_YEAR)) || ((state_q == ST_RUN) && !fits && last_year)) begin
			res_year_q  <= MAX_YEAR;
			res_month_q <= DECEMBER;
			res_day_q   <= LAST_DAY;
			res_ovf_q   <= 1'b1;
		end else if ((state_q == ST_RUN) && fits) begin
			res_year_q  <= year_q;
			res_month_q <= month_q;
			res_day_q   <= day_q[DAY_OUT_W-1:0];
			res_ovf_q   <= 1'b0;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign result_year   = res_year_q;
	assign result_month  = res_month_q;
	assign result_day    = res_day_q;
	assign year_overflow = res_ovf_q;

endmodule
